@@ rtl/tst_pkg.sv @@
// Package for the trajectory slot tracker: action and status codes, history entry type.
// No dependencies.
`default_nettype none
package tst_pkg;
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_EOF = 2'd2;
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL_TABLE = 2'd1;
    localparam logic [1:0] ST_HIST_FULL = 2'd2;
    localparam logic CFG_START_FRAME = 1'b0;
    localparam logic CFG_STILL_LIMIT = 1'b1;
    localparam int MIN_KEEP_LEN = 4;
    localparam int STILL_SPAN = 3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] vx;
        logic signed [16:0] vy;
        logic fg;
    } t_hist;
endpackage
`default_nettype wire

@@ rtl/tst_hist_mem.sv @@
// History memory of the trajectory slot tracker, one synchronous port pair.
// Depends on tst_pkg for the entry type.
`default_nettype none
module tst_hist_mem #(
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire tst_pkg::t_hist           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output tst_pkg::t_hist                o_rdata
);
    tst_pkg::t_hist mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/tst_still_chk.sv @@
// Stillness test of one history entry: background and squared speed under the limit.
// No package dependency; squares and flag are registered, the compare against the limit is combinational.
`default_nettype none
module tst_still_chk (
    input  wire logic              i_clk,
    input  wire logic signed [16:0] i_vx,
    input  wire logic signed [16:0] i_vy,
    input  wire logic              i_fg,
    input  wire logic [34:0]       i_limit,
    output logic                   o_still
);
    logic [33:0] r_sqx, r_sqy;
    logic        r_fg;
    always_ff @(posedge i_clk) begin
        r_sqx <= 34'(i_vx * i_vx);
        r_sqy <= 34'(i_vy * i_vy);
        r_fg  <= i_fg;
    end
    assign o_still = !r_fg && ({1'b0, r_sqx} + {1'b0, r_sqy} < i_limit);
endmodule
`default_nettype wire

@@ rtl/trajectory_slot_tracker_core.sv @@
// Top level of the trajectory slot tracker; depends on tst_pkg, tst_hist_mem and tst_still_chk.
// End of frame, no operation and an update outside the table go straight to the result; an update
// of an unused slot ends after the slot read; a lost point or an empty history skips the history
// reads. Allocate scans the slots from 0 for the first free one, or reports a full table.
// One item at a time: the next item can be accepted in the cycle after the result is taken.
// Synchronous active-low reset starts a clearing pass over all slots with no item accepted.
`default_nettype none
module trajectory_slot_tracker_core #(
    parameter int SLOTS = 256,
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] slot, [23:8] x_pos, [39:24] y_pos, [40] tracked_ok, [41] foreground
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] slot_out, [8] keep_tracking, [15:9] track_length, [24:16] used_count
    output logic [31:0]      m_axis_tdata,
    // [1:0] status
    output logic [1:0]       m_axis_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [34:0] i_cfg_data
);
    localparam int SW = $clog2(SLOTS);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int LW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = SW + HW;
    localparam int UW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SRD = 4'd2,
        S_UDEC = 4'd4, S_H1 = 4'd5, S_H2 = 4'd6, S_H3 = 4'd7, S_H4 = 4'd8,
        S_DEC = 4'd9, S_OUT = 4'd10, S_ALCW = 4'd11;

    logic [3:0]  r_state;
    logic [SW-1:0] r_ptr;
    logic [47:0] r_in;
    logic [LW-1:0] r_len;
    logic [UW-1:0] r_used;
    logic [31:0] r_frame;
    logic [34:0] r_limit;
    logic        r_valid;
    logic [7:0]  r_oslot;
    logic        r_okeep;
    logic [6:0]  r_olen;
    logic [1:0]  r_ostat;
    logic signed [16:0] r_vx, r_vy;
    logic        r_all_still;

    // Slot memory: in-use flag and length.
    logic [LW:0] slot_mem [SLOTS];
    logic [LW:0] r_slot_rd;
    logic        slot_we;
    logic [SW-1:0] slot_wa, slot_ra;
    logic [LW:0] slot_wd;
    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        r_slot_rd <= slot_mem[slot_ra];
    end
    logic [31:0] start_mem [SLOTS];
    logic        start_we;
    always_ff @(posedge i_clk) begin
        if (start_we) start_mem[slot_wa] <= r_frame;
    end

    logic [7:0] in_slot;
    logic signed [15:0] in_x, in_y;
    logic in_ok, in_fg;
    assign in_slot = r_in[7:0];
    assign in_x = r_in[23:8];
    assign in_y = r_in[39:24];
    assign in_ok = r_in[40];
    assign in_fg = r_in[41];

    tst_pkg::t_hist hist_rd, hist_wd;
    logic hist_we;
    logic [AW-1:0] hist_ra, hist_wa;
    tst_hist_mem #(.DEPTH(SLOTS * (2 ** HW))) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(hist_wa), .i_wdata(hist_wd),
        .i_raddr(hist_ra), .o_rdata(hist_rd)
    );

    logic signed [16:0] chk_vx, chk_vy;
    logic chk_fg, chk_still;
    tst_still_chk u_chk (
        .i_clk(i_clk), .i_vx(chk_vx), .i_vy(chk_vy), .i_fg(chk_fg),
        .i_limit(r_limit), .o_still(chk_still)
    );

    logic all_still;
    assign all_still = r_all_still && chk_still;
    logic [SW-1:0] uslot;
    assign uslot = SW'(in_slot);
    logic [LW-1:0] cur_len;
    assign cur_len = r_slot_rd[LW-1:0];

    assign s_axis_tready = (r_state == S_IDLE) && !r_valid;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata = {7'd0, 9'(r_used), r_olen, r_okeep, r_oslot};
    assign m_axis_tuser = r_ostat;

    always_comb begin
        slot_we = 1'b0;
        slot_wa = uslot;
        slot_wd = '0;
        start_we = 1'b0;
        slot_ra = uslot;
        hist_we = 1'b0;
        hist_wa = {uslot, HW'(r_len)};
        hist_wd = '{x: in_x, y: in_y, vx: r_vx, vy: r_vy, fg: in_fg};
        hist_ra = {uslot, HW'(r_len - LW'(1))};
        chk_vx = hist_rd.vx;
        chk_vy = hist_rd.vy;
        chk_fg = hist_rd.fg;
        unique case (r_state)
            S_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_ptr;
            end
            S_IDLE: slot_ra = (s_axis_tuser == tst_pkg::ACT_ALLOC) ? '0 :
                SW'(s_axis_tdata[7:0]);
            S_SRD: slot_ra = r_ptr;
            S_UDEC: hist_ra = {uslot, HW'(cur_len - LW'(1))};
            S_H2: begin
                chk_vx = r_vx;
                chk_vy = r_vy;
                chk_fg = in_fg;
                hist_ra = {uslot, HW'(r_len - LW'(2))};
            end
            S_H3: hist_ra = {uslot, HW'(r_len - LW'(3))};
            S_ALCW: begin
                slot_we = 1'b1;
                slot_wa = r_ptr;
                slot_wd = {1'b1, LW'(0)};
                start_we = 1'b1;
            end
            S_DEC: begin
                if (!in_ok) begin
                    if (r_len < LW'(tst_pkg::MIN_KEEP_LEN)) begin
                        slot_we = 1'b1;
                        slot_wd = {1'b0, r_len};
                    end
                end else if (r_len > LW'(tst_pkg::STILL_SPAN) && all_still) begin
                    slot_we = 1'b1;
                    slot_wd = {1'b1, r_len - LW'(tst_pkg::STILL_SPAN)};
                end else if (r_len < LW'(HISTORY_DEPTH)) begin
                    hist_we = 1'b1;
                    slot_we = 1'b1;
                    slot_wd = {1'b1, r_len + LW'(1)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr <= '0;
            r_valid <= 1'b0;
            r_used <= '0;
            r_frame <= '0;
            r_limit <= 35'd576;
        end else begin
            if (r_valid && m_axis_tready) r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == tst_pkg::CFG_START_FRAME) r_frame <= {1'b0, i_cfg_data[30:0]};
                else r_limit <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + SW'(1);
                    if (r_ptr == SW'(SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_in <= s_axis_tdata;
                    r_okeep <= 1'b0;
                    r_olen <= 7'd0;
                    r_ostat <= tst_pkg::ST_OK;
                    if (s_axis_tuser == tst_pkg::ACT_ALLOC) begin
                        r_oslot <= 8'd0;
                        r_state <= S_SRD;
                        r_ptr <= SW'(1);
                    end else if (s_axis_tuser == tst_pkg::ACT_UPDATE) begin
                        r_oslot <= s_axis_tdata[7:0];
                        r_state <= (32'(s_axis_tdata[7:0]) < 32'(SLOTS)) ? S_UDEC : S_OUT;
                    end else begin
                        r_oslot <= 8'd0;
                        if (s_axis_tuser == tst_pkg::ACT_EOF) r_frame <= r_frame + 32'd1;
                        r_state <= S_OUT;
                    end
                end
                S_SRD: begin
                    // r_slot_rd holds entry r_ptr-1.
                    if (!r_slot_rd[LW]) begin
                        r_ptr <= (r_ptr == '0) ? SW'(SLOTS - 1) : r_ptr - SW'(1);
                        r_state <= S_ALCW;
                    end else if (r_ptr == SW'(0)) begin
                        r_ostat <= tst_pkg::ST_FULL_TABLE;
                        r_state <= S_OUT;
                    end else r_ptr <= (r_ptr == SW'(SLOTS - 1)) ? '0 : r_ptr + SW'(1);
                end
                S_ALCW: begin
                    r_oslot <= 8'(r_ptr);
                    r_okeep <= 1'b1;
                    r_used <= r_used + UW'(1);
                    r_state <= S_OUT;
                end
                S_UDEC: begin
                    r_len <= cur_len;
                    r_olen <= 7'(cur_len);
                    if (!r_slot_rd[LW] || !in_ok) r_state <= r_slot_rd[LW] ? S_DEC : S_OUT;
                    else begin
                        r_vx <= '0;
                        r_vy <= '0;
                        r_state <= (cur_len == LW'(0)) ? S_DEC : S_H1;
                    end
                end
                S_H1: begin
                    r_vx <= 17'(in_x) - 17'(hist_rd.x);
                    r_vy <= 17'(in_y) - 17'(hist_rd.y);
                    r_state <= S_H2;
                end
                S_H2: begin
                    r_all_still <= chk_still;
                    r_state <= (r_len > LW'(tst_pkg::STILL_SPAN)) ? S_H3 : S_DEC;
                end
                S_H3: begin
                    r_all_still <= r_all_still & chk_still;
                    r_state <= S_H4;
                end
                S_H4: begin
                    r_all_still <= r_all_still & chk_still;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_OUT;
                    if (!in_ok) begin
                        if (r_len < LW'(tst_pkg::MIN_KEEP_LEN)) r_used <= r_used - UW'(1);
                    end else if (r_len > LW'(tst_pkg::STILL_SPAN) && all_still) begin
                        r_olen <= 7'(r_len - LW'(tst_pkg::STILL_SPAN));
                    end else if (r_len < LW'(HISTORY_DEPTH)) begin
                        r_okeep <= 1'b1;
                        r_olen <= 7'(r_len + LW'(1));
                    end else begin
                        r_okeep <= 1'b1;
                        r_ostat <= tst_pkg::ST_HIST_FULL;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_used) <= 32'(SLOTS))) else $error("used count overflow");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_valid) else $error("result lost");
endmodule
`default_nettype wire
